// File: rtl/sha256_pkg.sv
// Shared constants and a rotate function for the SHA-256 digest block.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [WordW-1:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadByte    = 8'h80;
  localparam logic [5:0] LengthSlot = 6'd56;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

// File: rtl/sha256_message_digest.sv
// SHA-256 message digest: byte stream in, eight digest words out.
//
// Input channel s_axis: one message byte per item in tdata, tuser flags that
// the byte is real, tlast closes the message. An item with tuser low and
// tlast high ends the message without a byte (covers the empty message).
// Output channel m_axis: eight items per message, digest word 0 first, tuser
// carries the word index and tlast marks word 7.
//
// Flow: a byte that neither fills a block nor closes the message leaves the
// input ready. The 64th byte of a block starts the compression: one shared
// round unit (one add tree, sigma functions, one schedule update) loads the
// working words (StLoad), runs 64 rounds, one a cycle (StRound), and folds
// the working words into the hash words (StFold); no new byte is taken
// until that is done. After tlast the padder feeds 0x80, zeros and the 64-bit
// length one byte a cycle (64 minus the fill), running one compression, or
// two when 0x80 lands at byte 56 or later, then the eight words leave one a
// cycle while the receiver takes them.
// s_axis_tready is low while padding, compressing or sending the digest.
// A stalled receiver holds the current digest word until taken.
// Reset (asynchronous, active low) loads the initial hash words, clears the
// length and fill counters and leaves the block ready for a new message.
module sha256_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StRound = 6'b000010,
    StFold  = 6'b000100,
    StPad   = 6'b001000,
    StOut   = 6'b010000,
    StLoad  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [WordW-1:0] h_q [8];
  logic [WordW-1:0] w_q [16];
  logic [WordW-1:0] v_q [8];
  logic [63:0]      bits_q;
  logic [5:0]       fill_q;
  logic [5:0]       round_q;
  logic [2:0]       out_idx_q;
  logic             pad_mode_q;   // message closed; padding, compression or digest output in progress
  logic             pad_first_q;  // next padding byte is 0x80
  logic [63:0]      pad_len_q;
  logic             len_done_q;     // the length bytes are in the block
  logic             len_in_block_q; // the current pad block takes the length

  logic in_fire, out_fire;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = h_q[out_idx_q];
  assign m_axis_tuser  = out_idx_q;
  assign m_axis_tlast  = (out_idx_q == 3'd7);

  // Padding byte for the current fill position: 0x80 first, length bytes only
  // in the block that carries the length, zeros elsewhere.
  logic [7:0] pad_byte;
  logic [2:0] len_sel;
  assign len_sel = 3'(fill_q - LengthSlot);
  always_comb begin
    if (pad_first_q) begin
      pad_byte = PadByte;
    end else if (len_in_block_q && fill_q >= LengthSlot) begin
      pad_byte = pad_len_q[8*(7 - len_sel) +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Shared round unit.
  logic [3:0]       r_idx;
  logic [WordW-1:0] w15, w2, sch, w_t, big1, ch, t1, big0, maj, t2;
  assign r_idx = round_q[3:0];
  assign w15   = w_q[4'(r_idx + 4'd1)];
  assign w2    = w_q[4'(r_idx + 4'd14)];
  assign sch   = w_q[r_idx] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
               + w_q[4'(r_idx + 4'd9)] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
  assign w_t   = round_q[5:4] == 2'd0 ? w_q[r_idx] : sch;
  assign big1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1    = v_q[7] + big1 + ch + RoundK[round_q] + w_t;
  assign big0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2    = big0 + maj;

  // Byte write into the block buffer.
  logic       byte_we;
  logic [7:0] byte_val;
  always_comb begin
    byte_we  = 1'b0;
    byte_val = s_axis_tdata;
    if (state_q == StIdle && in_fire && s_axis_tuser) begin
      byte_we = 1'b1;
    end else if (state_q == StPad) begin
      byte_we  = 1'b1;
      byte_val = pad_byte;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (s_axis_tuser && fill_q == 6'd63) state_d = StLoad;
          else if (s_axis_tlast)                state_d = StPad;
        end
      end
      StLoad:  state_d = StRound;
      StRound: if (round_q == 6'd63) state_d = StFold;
      StFold:  state_d = pad_mode_q ? (len_done_q ? StOut : StPad) : StIdle;
      StPad: begin
        if (fill_q == 6'd63) state_d = StLoad;
      end
      StOut:   if (out_fire && out_idx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bits_q      <= '0;
      fill_q      <= '0;
      round_q     <= '0;
      out_idx_q   <= '0;
      pad_mode_q  <= 1'b0;
      pad_first_q <= 1'b0;
      len_done_q  <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      state_q <= state_d;
      if (byte_we) fill_q <= fill_q + 6'd1;
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (s_axis_tuser) bits_q <= bits_q + 64'd8;
            if (s_axis_tlast) begin
              pad_mode_q  <= 1'b1;
              pad_first_q <= 1'b1;
              len_done_q  <= 1'b0;
            end
          end
        end
        StPad: begin
          pad_first_q <= 1'b0;
          if (fill_q == 6'd63 && len_in_block_q) len_done_q <= 1'b1;
        end
        StLoad:  round_q <= '0;
        StRound: round_q <= round_q + 6'd1;
        StFold: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        StOut: begin
          if (out_fire) begin
            out_idx_q <= out_idx_q + 3'd1;
            if (out_idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
              bits_q     <= '0;
              fill_q     <= '0;
              pad_mode_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The length goes into the first pad block when 0x80 lands before byte 56;
  // otherwise that block ends in zeros and the next block carries it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_in_block_q <= 1'b0;
    end else if (state_q == StIdle && in_fire && s_axis_tlast) begin
      len_in_block_q <= (fill_q + {5'd0, s_axis_tuser}) < LengthSlot;
    end else if (state_q == StFold && pad_mode_q) begin
      len_in_block_q <= 1'b1;
    end
  end

  // Block buffer, working words and length latch.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_fire && s_axis_tlast) begin
      pad_len_q <= bits_q + (s_axis_tuser ? 64'd8 : 64'd0);
    end
    if (byte_we) begin
      if (fill_q[1:0] == 2'd0) w_q[fill_q[5:2]] <= {byte_val, 24'd0};
      else w_q[fill_q[5:2]][8*(3 - fill_q[1:0]) +: 8] <= byte_val;
    end
    if (state_q == StLoad) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (state_q == StRound) begin
      if (round_q[5:4] != 2'd0) w_q[r_idx] <= sch;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
  end

endmodule

// File: rtl/sha256_checker.sv
// Port-level checker for the SHA-256 digest block, with its bind.
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open while digest pending");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("tlast not on word 7");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
    (m_axis_tvalid && m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
    else $error("digest words not contiguous");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("digest word changed while stalled");
endmodule

bind sha256_message_digest sha256_checker u_sha256_checker (.*);
